// ----- hw/rtl/spl_pkg.sv -----
// Shared types and constants for the shortest-path engine with line-switch penalty.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package spl_pkg;

  localparam int unsigned NUM_STATIONS      = 256;
  localparam int unsigned LINKS_PER_STATION = 16;
  localparam int unsigned STN_W    = 8;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned LINE_W   = 4;
  localparam int unsigned ETIME_W  = 16;
  localparam int unsigned TIME_W   = 20;
  localparam int unsigned PEN_W    = 5;
  localparam int unsigned EADDR_W  = STN_W + SLOT_W;
  localparam int unsigned EDGE_SLOTS = NUM_STATIONS * LINKS_PER_STATION;
  localparam int unsigned QCNT_W   = EADDR_W + 1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [PEN_W-1:0]  PEN_RESET = 5'd5;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [STN_W-1:0]   dest;
    logic [LINE_W-1:0]  line;
    logic [ETIME_W-1:0] etime;
  } edge_t;

  typedef struct packed {
    logic               settled;
    logic [STN_W-1:0]   prev;
    logic [LINE_W-1:0]  line;
    logic [TIME_W-1:0]  atime;
  } rec_t;

  typedef struct packed {
    logic [TIME_W-1:0]  atime;
    logic [EADDR_W-1:0] seq;
    logic [STN_W-1:0]   from;
    logic [STN_W-1:0]   dest;
    logic [LINE_W-1:0]  line;
  } qent_t;

  typedef struct packed {
    logic clr_step;
    logic latch;
    logic edge_wr;
    logic rclr_step;
    logic start_init;
    logic edge_rd;
    logic rec_rd_dest;
    logic push;
    logic slot_next;
    logic scan_done;
    logic q_rd;
    logic cmp;
    logic last_rd;
    logic move;
    logic rec_rd_best;
    logic settle;
    logic rec_rd_st;
    logic rec_rd_tgt;
    logic res_rec;
    logic res_zero;
    logic res_hit;
  } cmd_t;

  typedef struct packed {
    logic in_st_ok;
    logic clr_last;
    logic rclr_last;
    logic cur_is_tgt;
    logic exhausted;
    logic edge_valid;
    logic dest_ok;
    logic rec_settled;
    logic slot_last;
    logic q_empty;
    logic pop_last;
  } stat_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_EDGE_WR, S_RD_ST, S_RD_OUT, S_ZERO_OUT, S_REC_CLR, S_START,
    S_LOOP, S_SC_RD, S_SC_EDGE, S_SC_REC, S_POP_RD, S_POP_CMP, S_LAST_RD, S_MOVE,
    S_BEST_RD, S_SETTLE, S_TGT_RD, S_TGT_OUT
  } state_e;

endpackage

// ----- hw/rtl/spl_ctrl.sv -----
// Sequencer for the search engine: decodes ops and steps the datapath.
// Depends on spl_pkg; talks to spl_dpath only through cmd_t and stat_t.
`timescale 1ns / 1ps
module spl_ctrl import spl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] op_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:    if (stat_i.clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (op_i)
            OP_WRITE:  state_d = S_EDGE_WR;
            OP_SEARCH: state_d = stat_i.in_st_ok ? S_REC_CLR : S_ZERO_OUT;
            OP_READ:   state_d = stat_i.in_st_ok ? S_RD_ST : S_ZERO_OUT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_EDGE_WR:  state_d = S_IDLE;
      S_RD_ST:    state_d = S_RD_OUT;
      S_RD_OUT:   state_d = S_IDLE;
      S_ZERO_OUT: state_d = S_IDLE;
      S_REC_CLR:  if (stat_i.rclr_last) state_d = S_START;
      S_START:    state_d = S_LOOP;
      S_LOOP: begin
        if (stat_i.cur_is_tgt)      state_d = S_TGT_RD;
        else if (!stat_i.exhausted) state_d = S_SC_RD;
        else if (stat_i.q_empty)    state_d = S_TGT_RD;
        else                        state_d = S_POP_RD;
      end
      S_SC_RD: state_d = S_SC_EDGE;
      S_SC_EDGE: begin
        if (!stat_i.edge_valid)   state_d = S_LOOP;
        else if (!stat_i.dest_ok) state_d = stat_i.slot_last ? S_LOOP : S_SC_RD;
        else                      state_d = S_SC_REC;
      end
      S_SC_REC:  state_d = stat_i.slot_last ? S_LOOP : S_SC_RD;
      S_POP_RD:  state_d = S_POP_CMP;
      S_POP_CMP: state_d = stat_i.pop_last ? S_LAST_RD : S_POP_RD;
      S_LAST_RD: state_d = S_MOVE;
      S_MOVE:    state_d = S_BEST_RD;
      S_BEST_RD: state_d = S_SETTLE;
      S_SETTLE:  state_d = S_LOOP;
      S_TGT_RD:  state_d = S_TGT_OUT;
      S_TGT_OUT: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = (state_q != S_IDLE);
    case (state_q)
      S_INIT:     cmd_o.clr_step = 1'b1;
      S_IDLE:     cmd_o.latch = start;
      S_EDGE_WR:  cmd_o.edge_wr = 1'b1;
      S_RD_ST:    cmd_o.rec_rd_st = 1'b1;
      S_RD_OUT:   cmd_o.res_rec = 1'b1;
      S_ZERO_OUT: cmd_o.res_zero = 1'b1;
      S_REC_CLR:  cmd_o.rclr_step = 1'b1;
      S_START:    cmd_o.start_init = 1'b1;
      S_SC_RD:    cmd_o.edge_rd = 1'b1;
      S_SC_EDGE: begin
        if (!stat_i.edge_valid) begin
          cmd_o.scan_done = 1'b1;
        end else if (!stat_i.dest_ok) begin
          cmd_o.slot_next = 1'b1;
          cmd_o.scan_done = stat_i.slot_last;
        end else begin
          cmd_o.rec_rd_dest = 1'b1;
        end
      end
      S_SC_REC: begin
        cmd_o.push      = !stat_i.rec_settled;
        cmd_o.slot_next = 1'b1;
        cmd_o.scan_done = stat_i.slot_last;
      end
      S_POP_RD:  cmd_o.q_rd = 1'b1;
      S_POP_CMP: cmd_o.cmp = 1'b1;
      S_LAST_RD: cmd_o.last_rd = 1'b1;
      S_MOVE:    cmd_o.move = 1'b1;
      S_BEST_RD: cmd_o.rec_rd_best = 1'b1;
      S_SETTLE:  cmd_o.settle = !stat_i.rec_settled;
      S_TGT_RD:  cmd_o.rec_rd_tgt = 1'b1;
      S_TGT_OUT: cmd_o.res_hit = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ----- hw/rtl/spl_dpath.sv -----
// Datapath: edge table, station records, frontier queue, counters and result registers.
// Depends on spl_pkg; driven by spl_ctrl commands.
`timescale 1ns / 1ps
module spl_dpath import spl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic [STN_W-1:0]    station_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic                edge_valid_i,
  input  logic [STN_W-1:0]    dest_station_i,
  input  logic [LINE_W-1:0]   line_id_i,
  input  logic [ETIME_W-1:0]  edge_time_i,
  input  logic [STN_W-1:0]    target_station_i,
  input  logic                cfg_we_i,
  input  logic [PEN_W-1:0]    cfg_wdata_i,
  output logic                done_o,
  output logic                reached_o,
  output logic [TIME_W-1:0]   arrival_time_o,
  output logic [STN_W-1:0]    prev_station_o,
  output logic [LINE_W-1:0]   arrival_line_o
);

  edge_t edge_mem [EDGE_SLOTS];
  rec_t  rec_mem  [NUM_STATIONS];
  qent_t q_mem    [EDGE_SLOTS];

  edge_t edge_rdata_q;
  rec_t  rec_rdata_q;
  qent_t q_rdata_q;

  logic [PEN_W-1:0]   pen_q;
  logic [EADDR_W-1:0] clr_q;
  logic [STN_W-1:0]   rclr_q;
  logic [STN_W-1:0]   station_q, target_q, dest_q, cur_q;
  logic [SLOT_W-1:0]  slot_q, scan_q;
  logic               evalid_q;
  logic [LINE_W-1:0]  line_q, cur_line_q;
  logic [ETIME_W-1:0] etime_q;
  logic [TIME_W-1:0]  cur_time_q;
  logic               exh_q;
  logic [QCNT_W-1:0]  q_cnt_q;
  logic [QCNT_W-1:0]  seq_q;
  logic [EADDR_W-1:0] idx_q, best_idx_q;
  qent_t              best_q;
  logic               done_q, reached_q;
  logic [TIME_W-1:0]  time_q;
  logic [STN_W-1:0]   prev_q;
  logic [LINE_W-1:0]  aline_q;

  logic [STN_W-1:0]   rec_raddr;
  logic [TIME_W:0]    sum1, sum2;
  logic [TIME_W-1:0]  t1, t_push;
  logic               better;
  logic [QCNT_W-1:0]  last_idx;

  // Saturating times: edge add, then switch penalty in Q.4 units
  assign sum1   = {1'b0, cur_time_q} + {{(TIME_W-ETIME_W+1){1'b0}}, edge_rdata_q.etime};
  assign t1     = sum1[TIME_W] ? TIME_MAX : sum1[TIME_W-1:0];
  assign sum2   = {1'b0, t1} + {{(TIME_W-PEN_W-3){1'b0}}, pen_q, 4'b0000};
  assign t_push = ((cur_q != station_q) && (cur_line_q != edge_rdata_q.line))
                  ? (sum2[TIME_W] ? TIME_MAX : sum2[TIME_W-1:0]) : t1;

  assign better = (idx_q == '0) || (q_rdata_q.atime < best_q.atime) ||
                  ((q_rdata_q.atime == best_q.atime) && (q_rdata_q.seq < best_q.seq));
  assign last_idx = q_cnt_q - 1'b1;

  always_comb begin
    rec_raddr = station_q;
    if (cmd_i.rec_rd_dest)      rec_raddr = edge_rdata_q.dest;
    else if (cmd_i.rec_rd_best) rec_raddr = best_q.dest;
    else if (cmd_i.rec_rd_tgt)  rec_raddr = target_q;
    else if (cmd_i.rec_rd_st)   rec_raddr = station_q;
  end

  // Edge table
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      edge_mem[clr_q] <= '0;
    end else if (cmd_i.edge_wr && ({1'b0, station_q} < (STN_W+1)'(NUM_STATIONS))
                 && ({1'b0, slot_q} < (SLOT_W+1)'(LINKS_PER_STATION))) begin
      edge_mem[{station_q, slot_q}] <= '{evalid_q, dest_q, line_q, etime_q};
    end
    if (cmd_i.edge_rd) begin
      edge_rdata_q <= edge_mem[{cur_q, scan_q}];
    end
  end

  // Station records
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && (clr_q[EADDR_W-1:STN_W] == '0)) begin
      rec_mem[clr_q[STN_W-1:0]] <= '0;
    end else if (cmd_i.rclr_step) begin
      rec_mem[rclr_q] <= '0;
    end else if (cmd_i.start_init) begin
      rec_mem[station_q] <= '{1'b1, '0, '0, '0};
    end else if (cmd_i.settle) begin
      rec_mem[best_q.dest] <= '{1'b1, best_q.from, best_q.line, best_q.atime};
    end
    rec_rdata_q <= rec_mem[rec_raddr];
  end

  // Frontier queue, unordered; pop scans for least (time, seq)
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      q_mem[q_cnt_q[EADDR_W-1:0]] <= '{t_push, seq_q[EADDR_W-1:0], cur_q,
                                      edge_rdata_q.dest, edge_rdata_q.line};
    end else if (cmd_i.move) begin
      q_mem[best_idx_q] <= q_rdata_q;
    end
    if (cmd_i.q_rd) begin
      q_rdata_q <= q_mem[idx_q];
    end else if (cmd_i.last_rd) begin
      q_rdata_q <= q_mem[last_idx[EADDR_W-1:0]];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      station_q <= station_i;
      slot_q    <= slot_i;
      evalid_q  <= edge_valid_i;
      dest_q    <= dest_station_i;
      line_q    <= line_id_i;
      etime_q   <= edge_time_i;
      target_q  <= target_station_i;
    end
    if (cmd_i.cmp && better) begin
      best_q     <= q_rdata_q;
      best_idx_q <= idx_q;
    end
    if (cmd_i.res_rec) begin
      reached_q <= rec_rdata_q.settled;
      time_q    <= rec_rdata_q.atime;
      prev_q    <= rec_rdata_q.prev;
      aline_q   <= rec_rdata_q.line;
    end else if (cmd_i.res_hit) begin
      reached_q <= rec_rdata_q.settled;
      time_q    <= rec_rdata_q.settled ? rec_rdata_q.atime : '0;
      prev_q    <= '0;
      aline_q   <= '0;
    end else if (cmd_i.res_zero) begin
      reached_q <= 1'b0;
      time_q    <= '0;
      prev_q    <= '0;
      aline_q   <= '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q      <= PEN_RESET;
      clr_q      <= '0;
      rclr_q     <= '0;
      cur_q      <= '0;
      cur_line_q <= '0;
      cur_time_q <= '0;
      exh_q      <= 1'b0;
      scan_q     <= '0;
      q_cnt_q    <= '0;
      seq_q      <= '0;
      idx_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_we_i) pen_q <= cfg_wdata_i;
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.rclr_step) rclr_q <= rclr_q + 1'b1;
      done_q <= cmd_i.res_rec | cmd_i.res_hit | cmd_i.res_zero;
      if (cmd_i.start_init) begin
        cur_q      <= station_q;
        cur_line_q <= '0;
        cur_time_q <= '0;
        exh_q      <= 1'b0;
        scan_q     <= '0;
        q_cnt_q    <= '0;
        seq_q      <= '0;
        idx_q      <= '0;
      end
      if (cmd_i.scan_done) begin
        scan_q <= '0;
        exh_q  <= 1'b1;
      end else if (cmd_i.slot_next) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.push) begin
        q_cnt_q <= q_cnt_q + 1'b1;
        seq_q   <= seq_q + 1'b1;
      end
      if (cmd_i.cmp) idx_q <= idx_q + 1'b1;
      if (cmd_i.move) begin
        q_cnt_q <= last_idx;
        idx_q   <= '0;
      end
      if (cmd_i.settle) begin
        cur_q      <= best_q.dest;
        cur_line_q <= best_q.line;
        cur_time_q <= best_q.atime;
        exh_q      <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.in_st_ok    = ({1'b0, station_i} < (STN_W+1)'(NUM_STATIONS));
    stat_o.clr_last    = (clr_q == EADDR_W'(EDGE_SLOTS - 1));
    stat_o.rclr_last   = (rclr_q == STN_W'(NUM_STATIONS - 1));
    stat_o.cur_is_tgt  = (cur_q == target_q);
    stat_o.exhausted   = exh_q;
    stat_o.edge_valid  = edge_rdata_q.valid;
    stat_o.dest_ok     = ({1'b0, edge_rdata_q.dest} < (STN_W+1)'(NUM_STATIONS));
    stat_o.rec_settled = rec_rdata_q.settled;
    stat_o.slot_last   = (scan_q == SLOT_W'(LINKS_PER_STATION - 1));
    stat_o.q_empty     = (q_cnt_q == '0);
    stat_o.pop_last    = ({1'b0, idx_q} == last_idx);
  end

  assign done_o         = done_q;
  assign reached_o      = reached_q;
  assign arrival_time_o = time_q;
  assign prev_station_o = prev_q;
  assign arrival_line_o = aline_q;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held longer than one cycle");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (q_cnt_q < QCNT_W'(EDGE_SLOTS))) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move |-> (q_cnt_q != '0)) else $error("pop from empty queue");

endmodule

// ----- hw/rtl/shortest_path_line_penalty.sv -----
// Top level of the shortest-path engine with line-switch penalty.
// Depends on spl_pkg, spl_ctrl and spl_dpath.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------------
//  command   | start, busy             | op_i station_i slot_i edge_valid_i dest_station_i
//            |                         | line_id_i edge_time_i target_station_i
//  config    | cfg_we_i                | cfg_wdata_i (switch penalty, minutes)
//  result    | done_o (one-cycle)      | reached_o arrival_time_o prev_station_o
//            |                         | arrival_line_o
//
// After reset the edge table and station records are swept clear while busy is high.
// An unknown op gives no result. Op 1 clears the station records, scans the edges of
// each station that it settles and pops the frontier queue with a linear min scan.
// Results cannot be stalled: done_o pulses for one cycle, and the next command can be taken with it.
`timescale 1ns / 1ps
module shortest_path_line_penalty import spl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op_i,
  input  logic [STN_W-1:0]    station_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic                edge_valid_i,
  input  logic [STN_W-1:0]    dest_station_i,
  input  logic [LINE_W-1:0]   line_id_i,
  input  logic [ETIME_W-1:0]  edge_time_i,
  input  logic [STN_W-1:0]    target_station_i,
  input  logic                cfg_we_i,
  input  logic [PEN_W-1:0]    cfg_wdata_i,
  output logic                done_o,
  output logic                reached_o,
  output logic [TIME_W-1:0]   arrival_time_o,
  output logic [STN_W-1:0]    prev_station_o,
  output logic [LINE_W-1:0]   arrival_line_o
);

  cmd_t  cmd;
  stat_t stat;

  spl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  spl_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .station_i        (station_i),
    .slot_i           (slot_i),
    .edge_valid_i     (edge_valid_i),
    .dest_station_i   (dest_station_i),
    .line_id_i        (line_id_i),
    .edge_time_i      (edge_time_i),
    .target_station_i (target_station_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .reached_o        (reached_o),
    .arrival_time_o   (arrival_time_o),
    .prev_station_o   (prev_station_o),
    .arrival_line_o   (arrival_line_o)
  );

endmodule

// ----- tb/shortest_path_line_penalty_tb.sv -----
// Testbench for shortest_path_line_penalty: loads edge slots, runs searches and reads
// station records, checking each result against an in-bench Dijkstra predictor.
// Depends on spl_pkg and the shortest_path_line_penalty RTL.
`timescale 1ns / 1ps
module shortest_path_line_penalty_tb;
  import spl_pkg::*;

  localparam int unsigned IDLE_LIMIT = 600000;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef struct {
    logic              reached;
    logic [TIME_W-1:0] atime;
    logic [STN_W-1:0]  prev;
    logic [LINE_W-1:0] line;
  } route_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          op_i = '0;
  logic [STN_W-1:0]    station_i = '0;
  logic [SLOT_W-1:0]   slot_i = '0;
  logic                edge_valid_i = 1'b0;
  logic [STN_W-1:0]    dest_station_i = '0;
  logic [LINE_W-1:0]   line_id_i = '0;
  logic [ETIME_W-1:0]  edge_time_i = '0;
  logic [STN_W-1:0]    target_station_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [PEN_W-1:0]    cfg_wdata_i = '0;
  logic                done_o;
  logic                reached_o;
  logic [TIME_W-1:0]   arrival_time_o;
  logic [STN_W-1:0]    prev_station_o;
  logic [LINE_W-1:0]   arrival_line_o;

  shortest_path_line_penalty dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .station_i, .slot_i, .edge_valid_i,
    .dest_station_i, .line_id_i, .edge_time_i, .target_station_i, .cfg_we_i,
    .cfg_wdata_i, .done_o, .reached_o, .arrival_time_o, .prev_station_o, .arrival_line_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [PEN_W-1:0]   pen_min = PEN_RESET;
  logic               et_valid [EDGE_SLOTS];
  logic [STN_W-1:0]   et_dest  [EDGE_SLOTS];
  logic [LINE_W-1:0]  et_line  [EDGE_SLOTS];
  logic [ETIME_W-1:0] et_time  [EDGE_SLOTS];
  logic               st_settled [NUM_STATIONS];
  logic               st_done    [NUM_STATIONS];
  logic [STN_W-1:0]   st_prev    [NUM_STATIONS];
  logic [LINE_W-1:0]  st_line    [NUM_STATIONS];
  logic [TIME_W-1:0]  st_time    [NUM_STATIONS];
  logic [TIME_W-1:0]  fq_time [EDGE_SLOTS];
  int unsigned        fq_seq  [EDGE_SLOTS];
  logic [STN_W-1:0]   fq_from [EDGE_SLOTS];
  logic [STN_W-1:0]   fq_dest [EDGE_SLOTS];
  logic [LINE_W-1:0]  fq_line [EDGE_SLOTS];

  route_res_t pending_results[$];
  int unsigned errors = 0;
  int unsigned items = 0;
  int unsigned idle_cycles = 0;
  bit idle_en = 1'b1;

  function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > TIME_MAX) ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  task automatic clear_records();
    for (int i = 0; i < NUM_STATIONS; i++) begin
      st_settled[i] = 0; st_done[i] = 0; st_prev[i] = '0; st_line[i] = '0; st_time[i] = '0;
    end
  endtask

  task automatic find_route(int unsigned src, int unsigned tgt);
    int unsigned cur, cnt, seq, best, a;
    logic [TIME_W-1:0] t;
    clear_records();
    cur = src; cnt = 0; seq = 0;
    st_settled[src] = 1;
    while (cur != tgt) begin
      if (!st_done[cur]) begin
        for (int s = 0; s < LINKS_PER_STATION; s++) begin
          a = cur * LINKS_PER_STATION + s;
          if (!et_valid[a]) break;
          if (st_settled[et_dest[a]]) continue;
          t = sat_sum(st_time[cur], et_time[a]);
          if (cur != src && st_line[cur] != et_line[a]) t = sat_sum(t, pen_min * 16);
          if (cnt < EDGE_SLOTS) begin
            fq_time[cnt] = t; fq_seq[cnt] = seq; fq_from[cnt] = cur[STN_W-1:0];
            fq_dest[cnt] = et_dest[a]; fq_line[cnt] = et_line[a];
            cnt++; seq++;
          end
        end
        st_done[cur] = 1;
      end
      if (cnt == 0) break;
      best = 0;
      for (int i = 1; i < cnt; i++)
        if (fq_time[i] < fq_time[best] ||
            (fq_time[i] == fq_time[best] && fq_seq[i] < fq_seq[best])) best = i;
      if (!st_settled[fq_dest[best]]) begin
        st_settled[fq_dest[best]] = 1;
        st_prev[fq_dest[best]] = fq_from[best];
        st_line[fq_dest[best]] = fq_line[best];
        st_time[fq_dest[best]] = fq_time[best];
        cur = fq_dest[best];
      end
      cnt--;
      fq_time[best] = fq_time[cnt]; fq_seq[best] = fq_seq[cnt]; fq_from[best] = fq_from[cnt];
      fq_dest[best] = fq_dest[cnt]; fq_line[best] = fq_line[cnt];
    end
  endtask

  task automatic predict_item();
    route_res_t r;
    int unsigned a;
    r = '{1'b0, '0, '0, '0};
    case (op_i)
      OP_WRITE: begin
        a = station_i * LINKS_PER_STATION + slot_i;
        et_valid[a] = edge_valid_i; et_dest[a] = dest_station_i;
        et_line[a] = line_id_i; et_time[a] = edge_time_i;
      end
      OP_SEARCH: begin
        find_route(station_i, target_station_i);
        r.reached = st_settled[target_station_i];
        if (r.reached) r.atime = st_time[target_station_i];
        pending_results.push_back(r);
      end
      OP_READ: begin
        r.reached = st_settled[station_i]; r.atime = st_time[station_i];
        r.prev = st_prev[station_i]; r.line = st_line[station_i];
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // called just after a falling edge; returns just after the falling edge past the transfer
  task automatic send_cmd(logic [1:0] op, int unsigned st, int unsigned sl, logic ev,
                          int unsigned dst, int unsigned ln, int unsigned et, int unsigned tgt);
    if (idle_en && $urandom_range(3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    op_i = op; station_i = STN_W'(st); slot_i = SLOT_W'(sl); edge_valid_i = ev;
    dest_station_i = STN_W'(dst); line_id_i = LINE_W'(ln); edge_time_i = ETIME_W'(et);
    target_station_i = STN_W'(tgt);
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    idle_cycles = 0;
    predict_item();
    items++;
    @(negedge clk_i);
  endtask

  task automatic write_edge(int unsigned st, int unsigned sl, logic ev, int unsigned dst,
                            int unsigned ln, int unsigned et);
    send_cmd(OP_WRITE, st, sl, ev, dst, ln, et, $urandom_range(255));
  endtask

  task automatic run_search(int unsigned st, int unsigned tgt);
    send_cmd(OP_SEARCH, st, $urandom_range(15), 1'($urandom_range(1)), $urandom_range(255),
             $urandom_range(15), $urandom, tgt);
  endtask

  task automatic read_station(int unsigned st);
    send_cmd(OP_READ, st, $urandom_range(15), 1'($urandom_range(1)), $urandom_range(255),
             $urandom_range(15), $urandom, $urandom_range(255));
  endtask

  task automatic wait_drain();
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_penalty(logic [PEN_W-1:0] v);
    wait_drain();
    cfg_we_i = 1'b1; cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pen_min = v;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    route_res_t w;
    if (rst_ni && done_o) begin
      idle_cycles = 0;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_results.pop_front();
        if (reached_o !== w.reached) report_mismatch("reached", reached_o, w.reached);
        if (arrival_time_o !== w.atime) report_mismatch("arrival_time", arrival_time_o, w.atime);
        if (prev_station_o !== w.prev) report_mismatch("prev_station", prev_station_o, w.prev);
        if (arrival_line_o !== w.line) report_mismatch("arrival_line", arrival_line_o, w.line);
      end
    end
  end

  always @(posedge clk_i) begin
    idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** shortest_path_line_penalty: FAILED **");
      $finish;
    end
  end

  task automatic test_empty_graph();
    read_station(0);
    read_station(255);
    run_search(3, 3);            // start equals target
    read_station(3);
    run_search(7, 9);            // no edges: unreachable
  endtask

  task automatic test_line_switch();
    // 10 -> 11 on line 1, 11 -> 12 on line 2 (switch) vs 10 -> 12 direct slow
    write_edge(10, 0, 1, 11, 1, 16'h0010);
    write_edge(10, 1, 1, 12, 0, 16'h0200);
    write_edge(10, 2, 0, 0, 0, 0);          // empty slot ends the scan
    write_edge(10, 3, 1, 13, 0, 16'h0001);  // never scanned
    write_edge(11, 0, 1, 12, 2, 16'h0020);
    write_edge(11, 1, 1, 10, 3, 16'h0000);  // back to start: skipped
    write_edge(255, 15, 1, 0, 15, 16'hFFFF);
    send_cmd(OP_UNKNOWN, 10, 0, 1, 11, 1, 0, 12);
    run_search(10, 12);
    read_station(12);
    read_station(11);
    read_station(13);
  endtask

  task automatic test_penalty_extremes();
    set_penalty('0);
    run_search(10, 12);
    read_station(12);
    set_penalty('1);
    run_search(10, 12);
    read_station(12);
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 17; i++) write_edge(100 + i, 0, 1, 101 + i, i % 2, 16'hFFFF);
    run_search(100, 117);
    read_station(117);
  endtask

  task automatic test_random();
    int unsigned base, n, next_cfg;
    next_cfg = items + 30;
    while (items < 100) begin
      if (items >= 85) idle_en = 1'b0;
      if (items >= next_cfg) begin
        set_penalty(PEN_W'($urandom_range(31)));
        next_cfg = items + 30;
      end
      if (items >= 70 && items < 73) wait_drain();
      if ($urandom_range(9) < 7) begin
        base = $urandom_range(15);
        n = $urandom_range(1, 4);
        for (int s = 0; s < n; s++)
          write_edge(base, s, 1, $urandom_range(15), $urandom_range(3),
                     ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 8) * 16);
        if ($urandom_range(1)) write_edge(base, n, 0, $urandom_range(255),
                                          $urandom_range(15), $urandom);
        run_search($urandom_range(15), $urandom_range(15));
        repeat ($urandom_range(1, 2)) read_station($urandom_range(15));
      end else begin
        send_cmd(2'($urandom_range(3)), $urandom_range(255), $urandom_range(15),
                 1'($urandom_range(1)), $urandom_range(255), $urandom_range(15),
                 $urandom, $urandom_range(255));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < EDGE_SLOTS; i++) begin
      et_valid[i] = 0; et_dest[i] = '0; et_line[i] = '0; et_time[i] = '0;
    end
    clear_records();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_graph();
    test_line_switch();
    test_penalty_extremes();
    test_saturation();
    set_penalty(PEN_RESET);
    test_random();
    wait_drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** shortest_path_line_penalty: PASSED **");
    end else begin
      $display("** shortest_path_line_penalty: FAILED **");
    end
    $finish;
  end

endmodule
